### hw/rtl/assert_macros.svh
// Assertion macros for the RTL file that carries checks (the unit top level).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, ignored while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

### hw/rtl/mdio_mm_pkg.sv
// ----------------------------------------------------------------------------
// MDIO management master package
// Shared types, register map and frame codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mdio_mm_pkg;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [5:0]  PREAMBLE_RESET = 6'd33;
   localparam logic [15:0] NO_ACK_RESET   = 16'hBEEF;

   // register index is byte address bit 2
   typedef enum logic {
      CSR_PREAMBLE = 1'b0,
      CSR_NO_ACK   = 1'b1
   } csr_index_type;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   // start bits
   localparam logic [1:0] ST_C22 = 2'b01;
   localparam logic [1:0] ST_C45 = 2'b00;
   // opcodes
   localparam logic [1:0] OP_ADDRESS  = 2'b00;
   localparam logic [1:0] OP_WRITE    = 2'b01;
   localparam logic [1:0] OP_READ_C22 = 2'b10;
   localparam logic [1:0] OP_READ_C45 = 2'b11;

   typedef struct packed {
      logic        command;
      logic        is_write;
      logic        clause45;
      logic [4:0]  phy_addr;
      logic [20:0] reg_addr;
      logic [15:0] write_data;
      logic        mdio_in;
   } req_type;

   typedef struct packed {
      logic        mdio_out;
      logic        mdio_drive;
      logic        busy_res;
      logic        done_res;
      logic [15:0] read_data;
      logic        no_ack;
   } rsp_type;

   typedef struct packed {
      logic [5:0]  preamble_length;
      logic [15:0] no_ack_value;
   } csr_cfg_type;

endpackage

`default_nettype wire

### hw/rtl/mdio_mm_csr.sv
// ----------------------------------------------------------------------------
// MDIO master register file
// APB-style access to preamble length and no-ack read value.
// ----------------------------------------------------------------------------
`default_nettype none

module mdio_mm_csr import mdio_mm_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                           csr_pready,
   output csr_cfg_type                    cfg
);

   csr_cfg_type   cfg_ff, cfg_in;
   csr_index_type index;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign index      = csr_index_type'(csr_paddr[2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            CSR_PREAMBLE: cfg_in.preamble_length = csr_pwdata[5:0];
            CSR_NO_ACK:   cfg_in.no_ack_value    = csr_pwdata[15:0];
            default:      cfg_in                 = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         CSR_PREAMBLE: csr_prdata = {26'd0, cfg_ff.preamble_length};
         CSR_NO_ACK:   csr_prdata = {16'd0, cfg_ff.no_ack_value};
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.preamble_length <= PREAMBLE_RESET;
         cfg_ff.no_ack_value    <= NO_ACK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### hw/rtl/mdio_mm_engine.sv
// ----------------------------------------------------------------------------
// MDIO master frame engine
// Frame state and one MDC period of serialisation per tick item.
// ----------------------------------------------------------------------------
`default_nettype none

module mdio_mm_engine import mdio_mm_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   step_en,
   input  req_type     item,
   input  csr_cfg_type cfg,
   output rsp_type     result
);

   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_PRE   = 4'd1,
      PH_START = 4'd2,
      PH_PHY   = 4'd3,
      PH_REG   = 4'd4,
      PH_TA    = 4'd5,
      PH_DATA  = 4'd6,
      PH_END   = 4'd7,
      PH_RTA   = 4'd8,
      PH_RDATA = 4'd9,
      PH_SKIP  = 4'd10
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [5:0]  bit_counter_ff, bit_counter_in;
   logic [15:0] shift_word_ff, shift_word_in;
   logic        held_write_ff, held_write_in;
   logic        held_clause45_ff, held_clause45_in;
   logic [4:0]  held_phy_ff, held_phy_in;
   logic [20:0] held_address_ff, held_address_in;
   logic        addr_sent_ff, addr_sent_in;

   logic        addr_frame;
   logic [1:0]  opcode;
   logic [3:0]  start_code;
   logic [4:0]  reg_field;
   logic [4:0]  five_field;
   logic [15:0] data_word;
   logic [5:0]  bc_inc;
   logic        five_bit;
   phase_type   frame_entry;

   assign addr_frame  = held_clause45_ff & ~addr_sent_ff;
   assign bc_inc      = bit_counter_ff + 6'd1;
   assign frame_entry = (cfg.preamble_length == 6'd0) ? PH_START : PH_PRE;
   assign reg_field   = held_clause45_ff ? held_address_ff[20:16] : held_address_ff[4:0];
   assign five_field  = (phase_ff == PH_PHY) ? held_phy_ff : reg_field;
   assign data_word   = addr_frame ? held_address_ff[15:0] : shift_word_ff;

   always_comb begin
      priority if (addr_frame)  opcode = OP_ADDRESS;
      else if (held_write_ff)   opcode = OP_WRITE;
      else if (held_clause45_ff) opcode = OP_READ_C45;
      else                      opcode = OP_READ_C22;
   end
   assign start_code = {held_clause45_ff ? ST_C45 : ST_C22, opcode};

   // MSB first over a five-bit field
   always_comb begin
      unique case (bit_counter_ff[2:0])
         3'd0:    five_bit = five_field[4];
         3'd1:    five_bit = five_field[3];
         3'd2:    five_bit = five_field[2];
         3'd3:    five_bit = five_field[1];
         3'd4:    five_bit = five_field[0];
         default: five_bit = 1'b0;
      endcase
   end

   always_comb begin
      phase_in         = phase_ff;
      bit_counter_in   = bit_counter_ff;
      shift_word_in    = shift_word_ff;
      held_write_in    = held_write_ff;
      held_clause45_in = held_clause45_ff;
      held_phy_in      = held_phy_ff;
      held_address_in  = held_address_ff;
      addr_sent_in     = addr_sent_ff;
      result           = '0;

      if (item.command == CMD_START) begin
         if (phase_ff == PH_IDLE || phase_ff > PH_SKIP) begin
            held_write_in    = item.is_write;
            held_clause45_in = item.clause45;
            held_phy_in      = item.phy_addr;
            held_address_in  = item.reg_addr;
            shift_word_in    = item.is_write ? item.write_data : 16'd0;
            addr_sent_in     = 1'b0;
            bit_counter_in   = 6'd0;
            phase_in         = frame_entry;
         end
      end else begin
         unique case (phase_ff)
            PH_PRE: begin
               result.mdio_drive = 1'b1;
               result.mdio_out   = 1'b1;
               bit_counter_in    = bc_inc;
               if (bc_inc >= cfg.preamble_length) begin
                  phase_in       = PH_START;
                  bit_counter_in = 6'd0;
               end
            end
            PH_START: begin
               result.mdio_drive = 1'b1;
               result.mdio_out   = start_code[~bit_counter_ff[1:0]];
               bit_counter_in    = bc_inc;
               if (bc_inc >= 6'd4) begin
                  phase_in       = PH_PHY;
                  bit_counter_in = 6'd0;
               end
            end
            PH_PHY: begin
               result.mdio_drive = 1'b1;
               result.mdio_out   = five_bit;
               bit_counter_in    = bc_inc;
               if (bc_inc >= 6'd5) begin
                  phase_in       = PH_REG;
                  bit_counter_in = 6'd0;
               end
            end
            PH_REG: begin
               result.mdio_drive = 1'b1;
               result.mdio_out   = five_bit;
               bit_counter_in    = bc_inc;
               if (bc_inc >= 6'd5) begin
                  bit_counter_in = 6'd0;
                  phase_in       = (addr_frame || held_write_ff) ? PH_TA : PH_RTA;
               end
            end
            PH_TA: begin
               result.mdio_drive = 1'b1;
               result.mdio_out   = (bit_counter_ff == 6'd0);
               bit_counter_in    = bc_inc;
               if (bc_inc >= 6'd2) begin
                  phase_in       = PH_DATA;
                  bit_counter_in = 6'd0;
               end
            end
            PH_DATA: begin
               result.mdio_drive = 1'b1;
               result.mdio_out   = data_word[~bit_counter_ff[3:0]];
               bit_counter_in    = bc_inc;
               if (bc_inc >= 6'd16) begin
                  phase_in       = PH_END;
                  bit_counter_in = 6'd0;
               end
            end
            PH_END: begin
               if (addr_frame) begin
                  addr_sent_in   = 1'b1;
                  bit_counter_in = 6'd0;
                  phase_in       = frame_entry;
               end else begin
                  result.done_res  = 1'b1;
                  result.read_data = held_write_ff ? 16'd0 : shift_word_ff;
                  phase_in         = PH_IDLE;
                  bit_counter_in   = 6'd0;
               end
            end
            PH_RTA: begin
               bit_counter_in = 6'd0;
               phase_in       = item.mdio_in ? PH_SKIP : PH_RDATA;
            end
            PH_RDATA: begin
               shift_word_in  = {shift_word_ff[14:0], item.mdio_in};
               bit_counter_in = bc_inc;
               if (bc_inc >= 6'd16) begin
                  phase_in       = PH_END;
                  bit_counter_in = 6'd0;
               end
            end
            PH_SKIP: begin
               bit_counter_in = bc_inc;
               if (bc_inc >= 6'd32) begin
                  result.done_res  = 1'b1;
                  result.no_ack    = 1'b1;
                  result.read_data = cfg.no_ack_value;
                  phase_in         = PH_IDLE;
                  bit_counter_in   = 6'd0;
               end
            end
            default: begin
               phase_in       = PH_IDLE;
               bit_counter_in = 6'd0;
            end
         endcase
      end

      result.busy_res = (phase_in != PH_IDLE) && (phase_in <= PH_SKIP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         bit_counter_ff   <= 6'd0;
         shift_word_ff    <= 16'd0;
         held_write_ff    <= 1'b0;
         held_clause45_ff <= 1'b0;
         held_phy_ff      <= 5'd0;
         held_address_ff  <= 21'd0;
         addr_sent_ff     <= 1'b0;
      end else if (step_en) begin
         phase_ff         <= phase_in;
         bit_counter_ff   <= bit_counter_in;
         shift_word_ff    <= shift_word_in;
         held_write_ff    <= held_write_in;
         held_clause45_ff <= held_clause45_in;
         held_phy_ff      <= held_phy_in;
         held_address_ff  <= held_address_in;
         addr_sent_ff     <= addr_sent_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/mdio_management_master_unit.sv
// ----------------------------------------------------------------------------
// MDIO management master unit
// Clause 22 / clause 45 MDIO frame generator, one MDC period per tick.
// ----------------------------------------------------------------------------
// Use:
//   req_* carries one item per transfer: a start (command 0) latches the
//   request fields, a tick (command 1) advances the frame by one MDC
//   period and supplies the sampled MDIO level in req_mdio_in.
//   rsp_* returns exactly one result per item: the MDIO level and drive
//   enable for that period, busy, done, read data and no-ack.
//   csr_* is an APB-style port: preamble length at 0x0, no-ack read
//   value at 0x4. Write it only while no transaction is running.
// Timing:
//   An accepted item lands in the input register, is processed once the
//   output register is free and its result is registered there, which
//   drives rsp_valid. One item per cycle is sustained while rsp_ready
//   stays high; the only loop is the combinational frame state update.
// Reset:
//   synchronous; empties both registers, returns the frame engine to idle
//   and loads the register reset values (33 ones, no-ack value 0xBEEF).
// Back-pressure:
//   while rsp_ready is low the result holds; one further item is taken
//   into the input register, after which req_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module mdio_management_master_unit import mdio_mm_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // request channel
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_command,
   input  wire logic                      req_is_write,
   input  wire logic                      req_clause45,
   input  wire logic [4:0]                req_phy_addr,
   input  wire logic [20:0]               req_reg_addr,
   input  wire logic [15:0]               req_write_data,
   input  wire logic                      req_mdio_in,
   // result channel
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic                           rsp_mdio_out,
   output logic                           rsp_mdio_drive,
   output logic                           rsp_busy_res,
   output logic                           rsp_done_res,
   output logic [15:0]                    rsp_read_data,
   output logic                           rsp_no_ack,
   // configuration port
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                           csr_pready
);

`include "assert_macros.svh"

   csr_cfg_type cfg;

   // input register
   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   // output register
   logic    out_valid_ff, out_valid_in;
   rsp_type out_item_ff;
   rsp_type step_result;

   logic req_xfer;
   logic out_free;
   logic advance;

   mdio_mm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Output slot frees when empty or being taken this cycle; the input
   // register moves on into it whenever it does.
   assign out_free  = ~out_valid_ff | rsp_ready;
   assign advance   = in_valid_ff & out_free;
   assign req_ready = ~in_valid_ff | out_free;
   assign req_xfer  = req_valid & req_ready;

   assign in_valid_in  = req_xfer | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_ready);

   mdio_mm_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_item_ff.command    <= req_command;
         in_item_ff.is_write   <= req_is_write;
         in_item_ff.clause45   <= req_clause45;
         in_item_ff.phy_addr   <= req_phy_addr;
         in_item_ff.reg_addr   <= req_reg_addr;
         in_item_ff.write_data <= req_write_data;
         in_item_ff.mdio_in    <= req_mdio_in;
      end
      if (advance) begin
         out_item_ff <= step_result;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_mdio_out   = out_item_ff.mdio_out;
   assign rsp_mdio_drive = out_item_ff.mdio_drive;
   assign rsp_busy_res   = out_item_ff.busy_res;
   assign rsp_done_res   = out_item_ff.done_res;
   assign rsp_read_data  = out_item_ff.read_data;
   assign rsp_no_ack     = out_item_ff.no_ack;

   // ---- checks ----
   // a no-ack completion reports the programmed no-ack value
   `ASSERT_IMPLIES(a_noack_value, clock, reset, rsp_valid && rsp_no_ack, rsp_done_res && rsp_read_data == cfg.no_ack_value)
   // a finishing transfer leaves the engine idle
   `ASSERT_IMPLIES(a_done_not_busy, clock, reset, rsp_valid && rsp_done_res, !rsp_busy_res)
   // a released line never carries a driven one
   `ASSERT_IMPLIES(a_out_needs_drive, clock, reset, rsp_valid && rsp_mdio_out, rsp_mdio_drive)
   // a held item with a full, stalled output slot stays put
   `ASSERT_NEXT(a_hold_input, clock, reset, in_valid_ff && out_valid_ff && !rsp_ready, in_valid_ff && out_valid_ff)

endmodule

`default_nettype wire

### dv/tb_mdio_management_master_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MDIO management master unit testbench
// Drives start and tick transfers into the unit, predicts every MDC period
// (drive, level, busy, done, read data, no-ack) with an independent frame
// model and checks each result transfer against it, under random stalls on
// both channels and several register settings.
// ----------------------------------------------------------------------------

module tb_mdio_management_master_unit;
   import mdio_mm_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 100000;
   localparam int unsigned HOLD_CYCLES = 40;

   // Frame engine states, same order as the unit's phase encoding.
   typedef enum logic [3:0] {
      FR_IDLE, FR_PREAMBLE, FR_START, FR_PHY, FR_REG, FR_TA, FR_DATA, FR_END,
      FR_READ_TA, FR_READ_DATA, FR_SKIP
   } frame_state_type;

   // -------------------------------------------------------------------------
   // Scoreboard: frame model plus the queue of predicted MDC periods.
   // -------------------------------------------------------------------------
   class mdio_period_scoreboard;
      logic [5:0]      preamble_len;
      logic [15:0]     no_ack_word;
      frame_state_type state;
      logic [5:0]      bit_idx;
      logic [15:0]     shift_reg;
      logic            wr;
      logic            c45;
      logic            addr_done;
      logic [4:0]      phy;
      logic [20:0]     addr;
      rsp_type         expected_periods[$];
      int unsigned     errors;

      function new();
         preamble_len = PREAMBLE_RESET;
         no_ack_word  = NO_ACK_RESET;
         state        = FR_IDLE;
         bit_idx      = '0;
         shift_reg    = '0;
         wr           = 1'b0;
         c45          = 1'b0;
         addr_done    = 1'b0;
         phy          = '0;
         addr         = '0;
         errors       = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [31:0] value);
         case (idx)
            CSR_PREAMBLE: preamble_len = value[5:0];
            CSR_NO_ACK:   no_ack_word  = value[15:0];
         endcase
      endfunction

      function bit busy();
         return state != FR_IDLE;
      endfunction

      function int pending();
         return expected_periods.size();
      endfunction

      function bit address_phase();
         return c45 && !addr_done;
      endfunction

      function void open_frame();
         bit_idx = '0;
         state   = (preamble_len == 0) ? FR_START : FR_PREAMBLE;
      endfunction

      function rsp_type predict_period(req_type it);
         rsp_type     r;
         logic [3:0]  op_code;
         logic [4:0]  field;
         logic [15:0] word;
         r = '0;
         if (it.command == CMD_START) begin
            // a start while a frame runs is dropped
            if (state == FR_IDLE) begin
               wr        = it.is_write;
               c45       = it.clause45;
               phy       = it.phy_addr;
               addr      = it.reg_addr;
               shift_reg = it.is_write ? it.write_data : 16'h0000;
               addr_done = 1'b0;
               open_frame();
            end
         end else begin
            case (state)
               FR_PREAMBLE: begin
                  r.mdio_drive = 1'b1;
                  r.mdio_out   = 1'b1;
                  bit_idx      = bit_idx + 6'd1;
                  if (bit_idx >= preamble_len) begin
                     state   = FR_START;
                     bit_idx = '0;
                  end
               end
               FR_START: begin
                  if (address_phase())
                     op_code = {ST_C45, OP_ADDRESS};
                  else if (c45)
                     op_code = {ST_C45, wr ? OP_WRITE : OP_READ_C45};
                  else
                     op_code = {ST_C22, wr ? OP_WRITE : OP_READ_C22};
                  r.mdio_drive = 1'b1;
                  r.mdio_out   = op_code[3 - bit_idx[1:0]];
                  bit_idx      = bit_idx + 6'd1;
                  if (bit_idx >= 4) begin
                     state   = FR_PHY;
                     bit_idx = '0;
                  end
               end
               FR_PHY: begin
                  r.mdio_drive = 1'b1;
                  r.mdio_out   = phy[4 - bit_idx];
                  bit_idx      = bit_idx + 6'd1;
                  if (bit_idx >= 5) begin
                     state   = FR_REG;
                     bit_idx = '0;
                  end
               end
               FR_REG: begin
                  field        = c45 ? addr[20:16] : addr[4:0];
                  r.mdio_drive = 1'b1;
                  r.mdio_out   = field[4 - bit_idx];
                  bit_idx      = bit_idx + 6'd1;
                  if (bit_idx >= 5) begin
                     bit_idx = '0;
                     state   = (address_phase() || wr) ? FR_TA : FR_READ_TA;
                  end
               end
               FR_TA: begin
                  r.mdio_drive = 1'b1;
                  r.mdio_out   = (bit_idx == 0);
                  bit_idx      = bit_idx + 6'd1;
                  if (bit_idx >= 2) begin
                     state   = FR_DATA;
                     bit_idx = '0;
                  end
               end
               FR_DATA: begin
                  word         = address_phase() ? addr[15:0] : shift_reg;
                  r.mdio_drive = 1'b1;
                  r.mdio_out   = word[15 - bit_idx[3:0]];
                  bit_idx      = bit_idx + 6'd1;
                  if (bit_idx >= 16) begin
                     state   = FR_END;
                     bit_idx = '0;
                  end
               end
               FR_END: begin
                  if (address_phase()) begin
                     addr_done = 1'b1;
                     open_frame();
                  end else begin
                     r.done_res = 1'b1;
                     if (!wr)
                        r.read_data = shift_reg;
                     state   = FR_IDLE;
                     bit_idx = '0;
                  end
               end
               FR_READ_TA: begin
                  bit_idx = '0;
                  state   = it.mdio_in ? FR_SKIP : FR_READ_DATA;
               end
               FR_READ_DATA: begin
                  shift_reg = {shift_reg[14:0], it.mdio_in};
                  bit_idx   = bit_idx + 6'd1;
                  if (bit_idx >= 16) begin
                     state   = FR_END;
                     bit_idx = '0;
                  end
               end
               FR_SKIP: begin
                  bit_idx = bit_idx + 6'd1;
                  if (bit_idx >= 32) begin
                     r.done_res  = 1'b1;
                     r.no_ack    = 1'b1;
                     r.read_data = no_ack_word;
                     state       = FR_IDLE;
                     bit_idx     = '0;
                  end
               end
               default: begin
                  state   = FR_IDLE;
                  bit_idx = '0;
               end
            endcase
         end
         r.busy_res = (state != FR_IDLE);
         return r;
      endfunction

      function void note_item(req_type it);
         expected_periods.push_back(predict_period(it));
      endfunction

      function void compare_field(string field_name, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field_name, want, got);
         end
      endfunction

      function void check_period(rsp_type got);
         rsp_type want;
         if (expected_periods.size() == 0) begin
            errors++;
            $display("%0t: unexpected result transfer, actual 0x%0h", $time, got);
            return;
         end
         want = expected_periods.pop_front();
         compare_field("mdio_out",   want.mdio_out,   got.mdio_out);
         compare_field("mdio_drive", want.mdio_drive, got.mdio_drive);
         compare_field("busy_res",   want.busy_res,   got.busy_res);
         compare_field("done_res",   want.done_res,   got.done_res);
         compare_field("read_data",  want.read_data,  got.read_data);
         compare_field("no_ack",     want.no_ack,     got.no_ack);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and DUT signals. Every input has a known value from time 0.
   // -------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic        req_command    = CMD_TICK;
   logic        req_is_write   = 1'b0;
   logic        req_clause45   = 1'b0;
   logic [4:0]  req_phy_addr   = '0;
   logic [20:0] req_reg_addr   = '0;
   logic [15:0] req_write_data = '0;
   logic        req_mdio_in    = 1'b1;

   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic        rsp_mdio_out;
   logic        rsp_mdio_drive;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic [15:0] rsp_read_data;
   logic        rsp_no_ack;

   logic                      csr_psel    = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite  = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr   = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   mdio_period_scoreboard sb;

   int unsigned send_idle_pct = 0;   // chance that the sender idles before a transfer, drawn again while it idles
   int unsigned recv_idle_pct = 0;   // chance per cycle that the receiver stalls
   int unsigned items_sent    = 0;
   int unsigned cycle_count   = 0;
   int unsigned hold_left     = 0;
   bit          hold_request  = 1'b0;

   initial begin
      forever #2 clock = ~clock;
   end

   mdio_management_master_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_is_write   (req_is_write),
      .req_clause45   (req_clause45),
      .req_phy_addr   (req_phy_addr),
      .req_reg_addr   (req_reg_addr),
      .req_write_data (req_write_data),
      .req_mdio_in    (req_mdio_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_mdio_out   (rsp_mdio_out),
      .rsp_mdio_drive (rsp_mdio_drive),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_read_data  (rsp_read_data),
      .rsp_no_ack     (rsp_no_ack),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   // -------------------------------------------------------------------------
   // Monitor: values read at the rising edge are the ones from before it, so
   // a transfer here is exactly what the unit saw at this edge.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      req_type it;
      rsp_type got;
      if (!reset) begin
         if (req_valid && req_ready) begin
            it = '{req_command, req_is_write, req_clause45, req_phy_addr,
                   req_reg_addr, req_write_data, req_mdio_in};
            sb.note_item(it);
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_mdio_out, rsp_mdio_drive, rsp_busy_res, rsp_done_res,
                    rsp_read_data, rsp_no_ack};
            sb.check_period(got);
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off on request so the input
   // side fills up and has to back off.
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** mdio_management_master_unit: FAILED **");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Item builders
   // -------------------------------------------------------------------------
   function automatic req_type random_item();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[$bits(req_type)-1:0];
   endfunction

   // Start-only fields carry random junk on a tick; the unit must ignore them.
   function automatic req_type make_tick(logic level);
      req_type it;
      it         = random_item();
      it.command = CMD_TICK;
      it.mdio_in = level;
      return it;
   endfunction

   function automatic req_type make_start(logic is_wr, logic is_c45, logic [4:0] phy_a,
                                          logic [20:0] reg_a, logic [15:0] wdata);
      req_type it;
      it            = random_item();
      it.command    = CMD_START;
      it.is_write   = is_wr;
      it.clause45   = is_c45;
      it.phy_addr   = phy_a;
      it.reg_addr   = reg_a;
      it.write_data = wdata;
      return it;
   endfunction

   // -------------------------------------------------------------------------
   // Drivers. push_item returns at the edge its transfer happened; valid is
   // left high so a following item goes out back to back.
   // -------------------------------------------------------------------------
   task automatic push_item(input req_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= it.command;
      req_is_write   <= it.is_write;
      req_clause45   <= it.clause45;
      req_phy_addr   <= it.phy_addr;
      req_reg_addr   <= it.reg_addr;
      req_write_data <= it.write_data;
      req_mdio_in    <= it.mdio_in;
      do begin
         @(posedge clock);
      end while (!req_ready);
      items_sent++;
   endtask

   // One complete transaction: start, then exactly the ticks the frame needs.
   // The turnaround sample of a read decides between data and no-ack.
   task automatic run_transaction(input logic is_wr, input logic is_c45,
                                  input logic [4:0] phy_a, input logic [20:0] reg_a,
                                  input logic [15:0] wdata, input bit acked,
                                  input int unsigned stray_pct);
      int unsigned pre;
      int unsigned ticks;
      int unsigned ta_idx;
      pre = sb.preamble_len;
      push_item(make_start(is_wr, is_c45, phy_a, reg_a, wdata));
      ticks  = is_c45 ? pre + 33 : 0;      // clause 45 address frame
      ta_idx = ticks + pre + 14;           // read turnaround period
      if (is_wr)
         ticks = ticks + pre + 33;
      else
         ticks = ta_idx + 1 + (acked ? 17 : 32);
      for (int i = 0; i < ticks; i++) begin
         // a start dropped in mid-frame must be ignored
         if ($urandom_range(99) < stray_pct)
            push_item(make_start(1'($urandom), 1'($urandom), 5'($urandom),
                                 21'($urandom), 16'($urandom)));
         push_item(make_tick((!is_wr && i == ta_idx) ? !acked : 1'($urandom_range(1))));
      end
   endtask

   // Let every result come back and tick the engine back to idle, so the
   // registers can be written safely.
   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0 || sb.busy()) begin
         if (sb.pending() == 0) begin
            @(posedge clock);
            push_item(make_tick(1'($urandom_range(1))));
            req_valid <= 1'b0;
         end
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   // Two-phase register write; the register takes the value at the access edge.
   // The bus then returns to idle so that back-to-back writes each get a setup phase.
   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      sb.write_register(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly well-formed transactions with random content; the rest is noise
   // (random items, stray starts, idle ticks) that knocks the framing about.
   task automatic random_phase(input int unsigned target);
      int unsigned stop_at;
      stop_at = items_sent + target;
      while (items_sent < stop_at) begin
         if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(4, 1)) push_item(random_item());
         end else begin
            run_transaction(1'($urandom_range(1)), 1'($urandom_range(1)), 5'($urandom),
                            21'($urandom), 16'($urandom), $urandom_range(3) != 0, 3);
            if ($urandom_range(99) < 30)
               repeat ($urandom_range(2, 1)) push_item(make_tick(1'($urandom_range(1))));
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset values (33 preamble ones, 0xBEEF on no-ack); sender idles
      // lightly, receiver heavily. Tick while idle, then a clause 22 read
      // with every address bit set that the PHY never answers.
      send_idle_pct = 16;
      recv_idle_pct = 59;
      push_item(make_tick(1'b1));
      run_transaction(1'b0, 1'b0, 5'h1F, 21'h1FFFFF, 16'hFFFF, 1'b0, 0);
      settle();

      // No preamble at all, all-ones no-ack word; one of each operation.
      csr_write(CSR_PREAMBLE, 32'd0);
      csr_write(CSR_NO_ACK, 32'h0000FFFF);
      run_transaction(1'b1, 1'b0, 5'h1F, 21'h1FFFE0, 16'h0000, 1'b1, 0);
      run_transaction(1'b0, 1'b1, 5'h00, 21'h1F0000, 16'hFFFF, 1'b1, 0);
      run_transaction(1'b1, 1'b1, 5'h15, 21'h0AFFFF, 16'hFFFF, 1'b1, 10);
      run_transaction(1'b0, 1'b0, 5'h0A, 21'h000015, 16'h5A5A, 1'b0, 0);
      settle();

      // One-bit preamble, random no-ack word.
      csr_write(CSR_PREAMBLE, 32'd1);
      csr_write(CSR_NO_ACK, $urandom);
      random_phase(60);
      settle();

      // Swap the stall pattern round.
      send_idle_pct = 59;
      recv_idle_pct = 16;
      csr_write(CSR_PREAMBLE, $urandom_range(5, 0));
      csr_write(CSR_NO_ACK, $urandom);
      random_phase(60);
      settle();

      // Full-speed stretch. Longest preamble with a zero no-ack word, and the
      // receiver holding off long enough to back the unit up.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      csr_write(CSR_PREAMBLE, 32'd63);
      csr_write(CSR_NO_ACK, 32'd0);
      hold_request = 1'b1;
      run_transaction(1'b0, 1'b0, 5'($urandom), 21'($urandom), 16'($urandom), 1'b0, 3);
      settle();
      csr_write(CSR_PREAMBLE, $urandom_range(4, 2));
      random_phase(60);

      // Drain: every predicted period has to come back, then a short margin.
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0)
         @(negedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("** mdio_management_master_unit: PASSED **");
      else
         $display("** mdio_management_master_unit: FAILED **");
      $finish;
   end

endmodule

### mdio_management_master_unit.f
+incdir+hw/rtl
hw/rtl/mdio_mm_pkg.sv
hw/rtl/mdio_mm_csr.sv
hw/rtl/mdio_mm_engine.sv
hw/rtl/mdio_management_master_unit.sv
dv/tb_mdio_management_master_unit.sv
